// ----- rtl/cle_pkg.sv -----
// Shared types and codes for the contiguous list engine.
package cle_pkg;

  localparam int KEY_W = 32;

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_LINEAR = 2'd2;
  localparam logic [1:0] MODE_BINARY = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_EMPTY    = 3'd2;
  localparam logic [2:0] ST_BADPOS   = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;

  typedef struct packed {
    logic ins;
    logic rem;
    logic cmp;
  } cle_ctl_t;

endpackage

// ----- rtl/cle_cell.sv -----
// One list slot: holds an entry, shifts with its neighbors and compares against the key.
module cle_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 7
) (
  input  logic                              clk,
  input  cle_pkg::cle_ctl_t                 ctl,
  input  logic [CNT_W-1:0]                  pos,
  input  logic [CNT_W-1:0]                  count,
  input  logic signed [cle_pkg::KEY_W-1:0]  key,
  input  logic signed [cle_pkg::KEY_W-1:0]  left,
  input  logic signed [cle_pkg::KEY_W-1:0]  right,
  output logic signed [cle_pkg::KEY_W-1:0]  entry,
  output logic                              eq,
  output logic                              lt
);
  import cle_pkg::*;

  localparam logic [CNT_W:0] ME = (CNT_W + 1)'(IDX);

  logic [CNT_W:0]             pos_x;
  logic [CNT_W:0]             cnt_x;
  logic signed [KEY_W-1:0]    entry_r;
  logic signed [KEY_W-1:0]    entry_nxt;
  logic                       eq_r;
  logic                       lt_r;

  assign pos_x = {1'b0, pos};
  assign cnt_x = {1'b0, count};

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.ins) begin
      if (ME == pos_x) begin
        entry_nxt = key;
      end else if ((ME > pos_x) && (ME <= cnt_x)) begin
        entry_nxt = left;
      end
    end else if (ctl.rem) begin
      if ((ME >= pos_x) && ((ME + 1'b1) < cnt_x)) begin
        entry_nxt = right;
      end
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    if (ctl.cmp) begin
      eq_r <= (key == entry_r);
      lt_r <= (key < entry_r);
    end
  end

  assign entry = entry_r;
  assign eq    = eq_r;
  assign lt    = lt_r;

endmodule

// ----- rtl/contiguous_list_engine.sv -----
// Contiguous list engine top level: a row of list cells plus the search sequencer.
//
// A successful insert or remove shifts the cells from the given position onward, each
// from its neighbor, at once; every insert or remove delivers its word in the cycle
// after acceptance. A search first latches an equal and a less-than flag in every cell,
// then a sequencer steps one flag per cycle while the output is free: a linear search
// scans at most held_count entries, a binary one at most clog2(held_count + 1) entries.
// The input is stalled while a search runs or while an undelivered word is held.
// Capacity may be written only while the block is idle; 0 acts as 1 and values above
// DEPTH act as DEPTH. Entries carry no reset; only written entries are ever read.
module contiguous_list_engine #(
  parameter int DEPTH = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [6:0]                        cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        in_mode,
  input  logic [5:0]                        in_position,
  input  logic signed [cle_pkg::KEY_W-1:0]  in_key,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [2:0]                        out_status,
  output logic [5:0]                        out_found_index,
  output logic [6:0]                        out_comparisons,
  output logic [6:0]                        out_held_count
);
  import cle_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);
  localparam int EW    = (CNT_W > 7) ? CNT_W : 7;

  typedef enum logic [1:0] {S_IDLE, S_LINEAR, S_BINARY} state_t;

  state_t                    state_r;
  logic [CNT_W-1:0]          count_r;
  logic [6:0]                cap_r;
  logic [CNT_W-1:0]          scan_r;
  logic [CNT_W-1:0]          lo_r;
  logic [CNT_W-1:0]          hi_r;
  logic                      out_valid_r;
  logic [2:0]                out_status_r;
  logic [5:0]                out_found_r;
  logic [6:0]                out_cmps_r;
  logic [6:0]                out_held_r;

  logic                      acc;
  logic                      out_free;
  logic [EW-1:0]             cap_x;
  logic [EW-1:0]             eff_cap;
  logic [EW-1:0]             cnt_x;
  logic [EW-1:0]             pos_x;
  logic                      ins_full;
  logic                      ins_bad;
  logic                      rem_empty;
  logic                      rem_bad;
  logic                      ins_ok;
  logic                      rem_ok;
  logic [CNT_W-1:0]          count_up;
  logic [CNT_W-1:0]          count_dn;
  logic [CNT_W:0]            mid_sum;
  logic [CNT_W-1:0]          mid;
  logic [CNT_W-1:0]          lo_nxt;
  cle_ctl_t                  ctl;

  logic signed [KEY_W-1:0]   entries_w [DEPTH];
  logic [DEPTH-1:0]          eq_w;
  logic [DEPTH-1:0]          lt_w;

  function automatic logic [6:0] sat7(input logic [CNT_W-1:0] v);
    logic [EW-1:0] vx;
    vx = EW'(v);
    return (vx > EW'(127)) ? 7'd127 : vx[6:0];
  endfunction

  function automatic logic [5:0] low6(input logic [CNT_W-1:0] v);
    logic [EW-1:0] vx;
    vx = EW'(v);
    return vx[5:0];
  endfunction

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE) || !out_free;
  assign acc      = in_valid && !in_stall;

  assign cap_x   = EW'(cap_r);
  assign eff_cap = (cap_r == 7'd0) ? EW'(1) : ((cap_x > EW'(DEPTH)) ? EW'(DEPTH) : cap_x);
  assign cnt_x   = EW'(count_r);
  assign pos_x   = EW'(in_position);

  assign ins_full  = (cnt_x >= eff_cap);
  assign ins_bad   = (pos_x > cnt_x);
  assign rem_empty = (count_r == '0);
  assign rem_bad   = (pos_x >= cnt_x) || (pos_x >= eff_cap);
  assign ins_ok    = !ins_full && !ins_bad;
  assign rem_ok    = !rem_empty && !rem_bad;
  assign count_up  = count_r + 1'b1;
  assign count_dn  = count_r - 1'b1;

  assign ctl.ins = acc && (in_mode == MODE_INSERT) && ins_ok;
  assign ctl.rem = acc && (in_mode == MODE_REMOVE) && rem_ok;
  assign ctl.cmp = acc && ((in_mode == MODE_LINEAR) || (in_mode == MODE_BINARY));

  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r} - 1'b1;
  assign mid     = mid_sum[CNT_W:1];
  assign lo_nxt  = mid + 1'b1;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [KEY_W-1:0] left_w;
    logic signed [KEY_W-1:0] right_w;
    if (g == 0) begin : g_first
      assign left_w = in_key;
    end else begin : g_mid_l
      assign left_w = entries_w[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_w = entries_w[g];
    end else begin : g_mid_r
      assign right_w = entries_w[g+1];
    end
    cle_cell #(
      .IDX   (g),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk   (clk),
      .ctl   (ctl),
      .pos   (pos_x[CNT_W-1:0]),
      .count (count_r),
      .key   (in_key),
      .left  (left_w),
      .right (right_w),
      .entry (entries_w[g]),
      .eq    (eq_w[g]),
      .lt    (lt_w[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      cap_r       <= 7'd64;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (acc) begin
            out_found_r <= 6'd0;
            out_cmps_r  <= 7'd0;
            scan_r      <= '0;
            lo_r        <= '0;
            hi_r        <= count_r;
            case (in_mode)
              MODE_INSERT: begin
                out_valid_r <= 1'b1;
                if (ins_full) begin
                  out_status_r <= ST_FULL;
                  out_held_r   <= sat7(count_r);
                end else if (ins_bad) begin
                  out_status_r <= ST_BADPOS;
                  out_held_r   <= sat7(count_r);
                end else begin
                  out_status_r <= ST_OK;
                  out_held_r   <= sat7(count_up);
                  count_r      <= count_up;
                end
              end
              MODE_REMOVE: begin
                out_valid_r <= 1'b1;
                if (rem_empty) begin
                  out_status_r <= ST_EMPTY;
                  out_held_r   <= sat7(count_r);
                end else if (rem_bad) begin
                  out_status_r <= ST_BADPOS;
                  out_held_r   <= sat7(count_r);
                end else begin
                  out_status_r <= ST_OK;
                  out_held_r   <= sat7(count_dn);
                  count_r      <= count_dn;
                end
              end
              MODE_LINEAR: begin
                state_r <= S_LINEAR;
              end
              default: begin
                state_r <= S_BINARY;
              end
            endcase
          end
        end
        S_LINEAR: begin
          if (out_free) begin
            if (scan_r == count_r) begin
              out_status_r <= ST_NOTFOUND;
              out_found_r  <= 6'd0;
              out_cmps_r   <= sat7(count_r);
              out_held_r   <= sat7(count_r);
              out_valid_r  <= 1'b1;
              state_r      <= S_IDLE;
            end else if (eq_w[scan_r[IDX_W-1:0]]) begin
              out_status_r <= ST_OK;
              out_found_r  <= low6(scan_r);
              out_cmps_r   <= sat7(scan_r);
              out_held_r   <= sat7(count_r);
              out_valid_r  <= 1'b1;
              state_r      <= S_IDLE;
            end else begin
              scan_r <= scan_r + 1'b1;
            end
          end
        end
        S_BINARY: begin
          if (out_free) begin
            if (lo_r >= hi_r) begin
              out_status_r <= ST_NOTFOUND;
              out_found_r  <= 6'd0;
              out_cmps_r   <= sat7(scan_r);
              out_held_r   <= sat7(count_r);
              out_valid_r  <= 1'b1;
              state_r      <= S_IDLE;
            end else begin
              scan_r <= scan_r + 1'b1;
              if (eq_w[mid[IDX_W-1:0]]) begin
                out_status_r <= ST_OK;
                out_found_r  <= low6(mid);
                out_cmps_r   <= sat7(scan_r + 1'b1);
                out_held_r   <= sat7(count_r);
                out_valid_r  <= 1'b1;
                state_r      <= S_IDLE;
              end else if (lt_w[mid[IDX_W-1:0]]) begin
                hi_r <= mid;
              end else begin
                lo_r <= lo_nxt;
              end
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found_index = out_found_r;
  assign out_comparisons = out_cmps_r;
  assign out_held_count  = out_held_r;

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for the contiguous list engine: directed and random list operations.
`timescale 1ns / 1ps

module testbench;
  import cle_pkg::*;

  localparam int SLOTS = 64;
  localparam int MID_NONE = 0;
  localparam int MID_HOLD = 1;
  localparam int MID_PAUSE = 2;

  typedef struct packed {
    logic [2:0] status;
    logic [5:0] found_index;
    logic [6:0] comparisons;
    logic [6:0] held_count;
  } result_t;

  typedef struct packed {
    logic [1:0]         mode;
    logic [5:0]         position;
    logic signed [31:0] key;
  } item_t;

  class list_scoreboard;
    logic signed [31:0] keys [SLOTS];
    int unsigned        held;
    logic [6:0]         capacity;
    result_t            pending[$];
    int                 failures;

    function new();
      held = 0;
      capacity = 7'd64;
      failures = 0;
    endfunction

    function int unsigned usable_slots();
      if (capacity == 0) return 1;
      if (capacity > SLOTS) return SLOTS;
      return capacity;
    endfunction

    function void note_word(logic [1:0] mode, logic [5:0] pos, logic signed [31:0] key);
      result_t     r;
      int unsigned i;
      int unsigned lo;
      int unsigned hi;
      int unsigned mid;
      int unsigned cmps;
      r = '0;
      cmps = 0;
      case (mode)
        MODE_INSERT: begin
          if (held >= usable_slots()) begin
            r.status = ST_FULL;
          end else if (pos > held) begin
            r.status = ST_BADPOS;
          end else begin
            for (i = held; i > pos; i--) keys[i] = keys[i - 1];
            keys[pos] = key;
            held++;
          end
        end
        MODE_REMOVE: begin
          if (held == 0) begin
            r.status = ST_EMPTY;
          end else if (pos >= held || pos >= usable_slots()) begin
            r.status = ST_BADPOS;
          end else begin
            for (i = pos; i + 1 < held; i++) keys[i] = keys[i + 1];
            held--;
          end
        end
        MODE_LINEAR: begin
          r.status = ST_NOTFOUND;
          for (i = 0; i < held; i++) begin
            if (keys[i] == key) begin
              r.status = ST_OK;
              r.found_index = 6'(i);
              break;
            end
            cmps++;
          end
        end
        default: begin
          r.status = ST_NOTFOUND;
          lo = 0;
          hi = held;
          while (lo < hi) begin
            mid = (lo + hi - 1) / 2;
            cmps++;
            if (keys[mid] == key) begin
              r.status = ST_OK;
              r.found_index = 6'(mid);
              break;
            end else if (key < keys[mid]) begin
              hi = mid;
            end else begin
              lo = mid + 1;
            end
          end
        end
      endcase
      r.comparisons = 7'(cmps);
      r.held_count = 7'(held);
      pending.push_back(r);
    endfunction

    function void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        failures++;
      end
    endfunction

    function void check_word(result_t got);
      result_t want;
      if (pending.size() == 0) begin
        $error("result word with no expectation: status %0d", got.status);
        failures++;
        return;
      end
      want = pending.pop_front();
      check_field("status", want.status, got.status);
      check_field("found_index", want.found_index, got.found_index);
      check_field("comparisons", want.comparisons, got.comparisons);
      check_field("held_count", want.held_count, got.held_count);
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [6:0]         cfg_wdata;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         in_mode;
  logic [5:0]         in_position;
  logic signed [31:0] in_key;
  logic               out_valid;
  logic               out_stall;
  logic [2:0]         out_status;
  logic [5:0]         out_found_index;
  logic [6:0]         out_comparisons;
  logic [6:0]         out_held_count;

  list_scoreboard sb = new();
  bit             calm;
  int             hold_request;

  contiguous_list_engine dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_mode         (in_mode),
    .in_position     (in_position),
    .in_key          (in_key),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_found_index (out_found_index),
    .out_comparisons (out_comparisons),
    .out_held_count  (out_held_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) sb.capacity = cfg_wdata;
      if (in_valid && !in_stall) sb.note_word(in_mode, in_position, in_key);
      if (out_valid && !out_stall)
        sb.check_word('{out_status, out_found_index, out_comparisons, out_held_count});
    end
  end

  initial begin
    int n;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (hold_request > 0) begin
        n = hold_request;
        hold_request = 0;
      end else begin
        n = calm ? 0 : $urandom_range(0, 5);
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
      @(negedge clk);
    end
  end

  task automatic send_word(input item_t w);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= w.mode;
    in_position <= w.position;
    in_key <= w.key;
    do @(posedge clk); while (!(in_valid && !in_stall));
    @(negedge clk);
  endtask

  task automatic send(input logic [1:0] mode, input logic [5:0] pos, input logic [31:0] key);
    send_word('{mode, pos, key});
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (sb.pending.size() != 0);
  endtask

  task automatic write_capacity(input logic [6:0] value);
    wait_drain();
    repeat (4) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic item_t pick_word(int ins_pct, int rem_pct);
    item_t       w;
    int          roll;
    int unsigned n;
    int unsigned slot;
    n = sb.held;
    case ($urandom_range(0, 4))
      0, 1: w.key = $urandom;
      2, 3: w.key = $signed($urandom_range(0, 40)) - 20;
      default: begin
        case ($urandom_range(0, 3))
          0: w.key = 32'sh8000_0000;
          1: w.key = 32'sh7fff_ffff;
          2: w.key = 0;
          default: w.key = -1;
        endcase
      end
    endcase
    roll = $urandom_range(0, 99);
    if (roll < ins_pct) begin
      w.mode = MODE_INSERT;
      case ($urandom_range(0, 9))
        0: w.position = 6'($urandom);
        1: w.position = 6'($urandom_range(0, n));
        default: begin
          slot = 0;
          for (int i = 0; i < n; i++) if (sb.keys[i] < w.key) slot++;
          w.position = 6'(slot);
        end
      endcase
    end else if (roll < ins_pct + rem_pct) begin
      w.mode = MODE_REMOVE;
      if (n == 0 || $urandom_range(0, 7) == 0) w.position = 6'($urandom);
      else w.position = 6'($urandom_range(0, n - 1));
    end else begin
      w.mode = $urandom_range(0, 1) ? MODE_LINEAR : MODE_BINARY;
      w.position = 6'($urandom);
      if (n > 0 && $urandom_range(0, 2) != 0) w.key = sb.keys[$urandom_range(0, n - 1)];
    end
    return w;
  endfunction

  task automatic run_phase(input logic [6:0] cap, input int items, input int ins_pct,
                           input int rem_pct, input int mid_action);
    write_capacity(cap);
    calm = ($urandom_range(0, 2) == 0);
    for (int k = 0; k < items; k++) begin
      if (k == items / 2) begin
        if (mid_action == MID_HOLD) hold_request = 200;
        if (mid_action == MID_PAUSE) wait_drain();
      end
      send_word(pick_word(ins_pct, rem_pct));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_mode = MODE_INSERT;
    in_position = '0;
    in_key = '0;
    calm = 1'b0;
    hold_request = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send(MODE_LINEAR, 6'd0, 32'd0);
    send(MODE_BINARY, 6'd63, 32'hffff_ffff);
    send(MODE_REMOVE, 6'd0, 32'd0);
    send(MODE_INSERT, 6'd1, 32'd5);
    send(MODE_INSERT, 6'd0, 32'h8000_0000);
    send(MODE_INSERT, 6'd1, 32'h7fff_ffff);
    send(MODE_INSERT, 6'd1, 32'd0);
    send(MODE_INSERT, 6'd63, 32'd7);
    send(MODE_LINEAR, 6'd0, 32'h7fff_ffff);
    send(MODE_BINARY, 6'd0, 32'h8000_0000);
    send(MODE_BINARY, 6'd0, 32'd1);
    send(MODE_LINEAR, 6'd0, 32'd1);
    send(MODE_REMOVE, 6'd3, 32'd0);
    send(MODE_REMOVE, 6'd63, 32'd0);
    send(MODE_REMOVE, 6'd0, 32'd0);
    write_capacity(7'd0);
    send(MODE_INSERT, 6'd0, 32'd9);
    send(MODE_REMOVE, 6'd1, 32'd0);
    send(MODE_LINEAR, 6'd0, 32'h7fff_ffff);
    send(MODE_REMOVE, 6'd0, 32'd0);
    send(MODE_INSERT, 6'd0, 32'd3);
    send(MODE_REMOVE, 6'd0, 32'd0);
    send(MODE_REMOVE, 6'd0, 32'd0);
    send(MODE_INSERT, 6'd0, 32'hffff_ffff);

    run_phase(7'd64, 140, 60, 5, MID_HOLD);
    run_phase(7'd20, 50, 15, 45, MID_NONE);
    run_phase(7'd127, 60, 35, 25, MID_PAUSE);
    run_phase(7'd0, 40, 20, 50, MID_NONE);
    run_phase(7'd1, 40, 40, 30, MID_NONE);
    run_phase(7'($urandom_range(2, 63)), 60, 45, 20, MID_HOLD);
    run_phase(7'd2, 30, 40, 30, MID_NONE);
    run_phase(7'd64, 40, 20, 40, MID_NONE);

    wait_drain();
    repeat (70) @(posedge clk);
    if (sb.failures == 0) begin
      $display("[contiguous_list_engine] OK");
    end else begin
      $display("[contiguous_list_engine] ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("[contiguous_list_engine] ERROR");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/cle_pkg.sv
rtl/cle_cell.sv
rtl/contiguous_list_engine.sv
verif/testbench.sv
